[design/quaternion_to_euler_angles_defines.svh]
// Assertion macros used by the quaternion to Euler angles design.
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// Same-cycle implication under clock and reset.
`define QEA_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under clock and reset.
`define QEA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/qea_pkg.sv]
// Types, constants and helper functions for the quaternion to Euler angles pipeline.
`timescale 1ns / 1ps
`default_nettype none
package qea_pkg;
   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int TABLE_LEN       = 24;
   localparam int TAB_W           = $clog2(TABLE_LEN);
   localparam int ACC_FRAC        = 24;
   localparam int CW              = 37;
   localparam int AW              = 34;
   localparam int PW              = 34;
   localparam int SQ_STEPS        = 31;
   localparam int RW              = 62;
   localparam int SH_W            = 6;
   localparam int FRONT_STAGES    = 4;
   localparam int DEPTH           = FRONT_STAGES + SQ_STEPS + 1 + CORDIC_STEPS + 1;
   localparam int OUT_SH          = ACC_FRAC - ANGLE_FRAC_BITS;

   localparam logic signed [AW-1:0] ONE_Q30 = AW'(1) <<< 30;
   localparam logic signed [AW-1:0] ACC_90  = AW'(90) <<< ACC_FRAC;
   localparam logic signed [AW-1:0] RND     = AW'(1) <<< (OUT_SH - 1);
   localparam logic signed [AW-1:0] LIM_X   = AW'(180) <<< ANGLE_FRAC_BITS;
   localparam logic signed [AW-1:0] LIM_Y   = AW'(90) <<< ANGLE_FRAC_BITS;

   localparam logic signed [AW-1:0] ATAN_TABLE [TABLE_LEN] = '{
      34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
      34'sd60000934, 34'sd30029717, 34'sd15018523, 34'sd7509720,
      34'sd3754917, 34'sd1877466, 34'sd938734, 34'sd469367,
      34'sd234684, 34'sd117342, 34'sd58671, 34'sd29335,
      34'sd14668, 34'sd7334, 34'sd3667, 34'sd1833,
      34'sd917, 34'sd458, 34'sd229, 34'sd115
   };

   typedef struct packed {
      logic signed [PW-1:0] num_x;
      logic signed [PW-1:0] den_x;
      logic signed [PW-1:0] num_z;
      logic signed [PW-1:0] den_z;
      logic signed [31:0]   s;
   } side_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [RW-1:0] res;
   } sqrt_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] acc;
      logic                 zero;
   } lane_type;

   function automatic lane_type pre_rotate(input logic signed [CW-1:0] y,
                                           input logic signed [CW-1:0] x);
      lane_type l;
      l.zero = (x == '0) && (y == '0);
      l.x    = x;
      l.y    = y;
      l.acc  = '0;
      if (x < 0) begin
         if (y >= 0) begin
            l.x   = y;
            l.y   = -x;
            l.acc = ACC_90;
         end else begin
            l.x   = -y;
            l.y   = x;
            l.acc = -ACC_90;
         end
      end
      return l;
   endfunction

   function automatic logic signed [AW-1:0] to_angle(input logic signed [AW-1:0] acc,
                                                     input logic zero,
                                                     input logic signed [AW-1:0] lim);
      logic signed [AW-1:0] a;
      logic signed [AW-1:0] r;
      a = zero ? '0 : acc;
      r = (a + RND) >>> OUT_SH;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction
endpackage
`default_nettype wire

[design/qea_sqrt_cell.sv]
// One bit of the restoring square root, with the side lanes carried along.
`timescale 1ns / 1ps
`default_nettype none
module qea_sqrt_cell import qea_pkg::*; (
   input  wire logic            clock,
   input  wire logic            en,
   input  wire logic [SH_W-1:0] sh,
   input  wire sqrt_type        sq_i,
   input  wire side_type        side_i,
   output logic                 dummy_unused_n,
   output sqrt_type             sq_o,
   output side_type             side_o
);
   sqrt_type sq_in, sq_ff;
   side_type side_ff;
   logic [RW-1:0] bit_v, trial;

   always_comb begin
      bit_v = RW'(1) << sh;
      trial = sq_i.res + bit_v;
      if (sq_i.rem >= trial) begin
         sq_in.rem = sq_i.rem - trial;
         sq_in.res = (sq_i.res >> 1) + bit_v;
      end else begin
         sq_in.rem = sq_i.rem;
         sq_in.res = sq_i.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff   <= sq_in;
         side_ff <= side_i;
      end
   end

   assign dummy_unused_n = 1'b1;
   assign sq_o   = sq_ff;
   assign side_o = side_ff;
endmodule
`default_nettype wire

[design/qea_cordic_cell.sv]
// One vectoring CORDIC micro-rotation for one angle lane.
`timescale 1ns / 1ps
`default_nettype none
module qea_cordic_cell import qea_pkg::*; (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [TAB_W-1:0] step_idx,
   input  wire lane_type         lane_i,
   output lane_type              lane_o
);
   lane_type lane_in, lane_ff;
   logic signed [CW-1:0] dx, dy;

   always_comb begin
      dx = lane_i.y >>> step_idx;
      dy = lane_i.x >>> step_idx;
      lane_in.zero = lane_i.zero;
      if (lane_i.y >= 0) begin
         lane_in.x   = lane_i.x + dx;
         lane_in.y   = lane_i.y - dy;
         lane_in.acc = lane_i.acc + ATAN_TABLE[step_idx];
      end else begin
         lane_in.x   = lane_i.x - dx;
         lane_in.y   = lane_i.y + dy;
         lane_in.acc = lane_i.acc - ATAN_TABLE[step_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (en) lane_ff <= lane_in;
   end

   assign lane_o = lane_ff;
endmodule
`default_nettype wire

[design/qea_front.sv]
// Front stages: component products, atan2 operands, asin clamp and 1 - s^2.
`timescale 1ns / 1ps
`default_nettype none
module qea_front import qea_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [15:0] quat_x,
   input  wire logic signed [15:0] quat_y,
   input  wire logic signed [15:0] quat_z,
   input  wire logic signed [15:0] quat_w,
   output side_type                side_o,
   output logic [RW-1:0]           rad_o
);
   logic signed [31:0] xx_ff, yy_ff, zz_ff, ww_ff, yz_ff, wx_ff, wy_ff, xz_ff, xy_ff, wz_ff;
   side_type side_in, side_s_ff, side_q_ff, side_r_ff;
   logic signed [PW-1:0] s_raw;
   logic [30:0] mag_in, mag_ff;
   logic [29:0] hh_ff;
   logic [30:0] hl_ff;
   logic [31:0] ll_ff;
   logic [60:0] s2, rad_in;
   logic [RW-1:0] rad_ff;

   always_comb begin
      side_in.num_x = (PW'(yz_ff) + PW'(wx_ff)) <<< 1;
      side_in.den_x = PW'(ww_ff) - PW'(xx_ff) - PW'(yy_ff) + PW'(zz_ff);
      side_in.num_z = (PW'(xy_ff) + PW'(wz_ff)) <<< 1;
      side_in.den_z = PW'(ww_ff) + PW'(xx_ff) - PW'(yy_ff) - PW'(zz_ff);
      s_raw = (PW'(wy_ff) - PW'(xz_ff)) <<< 1;
      if (s_raw > ONE_Q30) s_raw = ONE_Q30;
      if (s_raw < -ONE_Q30) s_raw = -ONE_Q30;
      side_in.s = 32'(s_raw);
      mag_in = 31'(s_raw < 0 ? -s_raw : s_raw);
      s2 = (61'(hh_ff) << 32) + (61'(hl_ff) << 17) + 61'(ll_ff);
      rad_in = (61'(1) << 60) - s2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         zz_ff <= quat_z * quat_z;
         ww_ff <= quat_w * quat_w;
         yz_ff <= quat_y * quat_z;
         wx_ff <= quat_w * quat_x;
         wy_ff <= quat_w * quat_y;
         xz_ff <= quat_x * quat_z;
         xy_ff <= quat_x * quat_y;
         wz_ff <= quat_w * quat_z;
         side_s_ff <= side_in;
         mag_ff    <= mag_in;
         hh_ff     <= mag_ff[30:16] * mag_ff[30:16];
         hl_ff     <= mag_ff[30:16] * mag_ff[15:0];
         ll_ff     <= mag_ff[15:0] * mag_ff[15:0];
         side_q_ff <= side_s_ff;
         side_r_ff <= side_q_ff;
         rad_ff    <= RW'(rad_in);
      end
   end

   assign side_o = side_r_ff;
   assign rad_o  = rad_ff;
endmodule
`default_nettype wire

[design/quaternion_to_euler_angles.sv]
// Top level: quaternion to x-y-z Euler angles through a square-root and CORDIC cell chain.
//  channel | dir | ports
//  req     | in  | req_valid, req_stall, req_quat_x/y/z/w (Q1.15)
//  rsp     | out | rsp_valid, rsp_stall, rsp_angle_x/y/z_deg (deg, 7 frac bits)
// One item per cycle unless a stalled result holds the chain, which has 4 front stages,
// 31 square-root cells, one quadrant stage, 16 CORDIC cells and the output register.
// Synchronous reset clears the valid line only.
// A stalled result freezes the whole chain; req_stall follows it in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_to_euler_angles_defines.svh"
module quaternion_to_euler_angles import qea_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   input  wire logic signed [15:0] req_quat_w,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_angle_x_deg,
   output logic signed [14:0]      rsp_angle_y_deg,
   output logic signed [15:0]      rsp_angle_z_deg
);
   logic en;
   logic [DEPTH-1:0] vld_ff;
   side_type side_f;
   logic [RW-1:0] rad_f;
   sqrt_type sq_c [SQ_STEPS+1];
   side_type side_c [SQ_STEPS+1];
   logic [SQ_STEPS-1:0] cell_ok;
   lane_type pre_in [3];
   lane_type lane_c [3][CORDIC_STEPS+1];
   logic signed [15:0] ax_ff, az_ff;
   logic signed [14:0] ay_ff;
   logic signed [AW-1:0] ax, ay, az;

   assign en        = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   qea_front u_front (
      .clock(clock), .en(en),
      .quat_x(req_quat_x), .quat_y(req_quat_y), .quat_z(req_quat_z), .quat_w(req_quat_w),
      .side_o(side_f), .rad_o(rad_f)
   );

   assign sq_c[0].rem = rad_f;
   assign sq_c[0].res = '0;
   assign side_c[0]   = side_f;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      qea_sqrt_cell u_cell (
         .clock(clock), .en(en), .sh(SH_W'(2 * (SQ_STEPS - 1 - k))),
         .sq_i(sq_c[k]), .side_i(side_c[k]), .dummy_unused_n(cell_ok[k]),
         .sq_o(sq_c[k+1]), .side_o(side_c[k+1])
      );
   end

   always_comb begin
      pre_in[0] = pre_rotate(CW'(side_c[SQ_STEPS].num_x), CW'(side_c[SQ_STEPS].den_x));
      pre_in[1] = pre_rotate(CW'(side_c[SQ_STEPS].s),
                             $signed(CW'(sq_c[SQ_STEPS].res[30:0])));
      pre_in[2] = pre_rotate(CW'(side_c[SQ_STEPS].num_z), CW'(side_c[SQ_STEPS].den_z));
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      always_ff @(posedge clock) begin
         if (en) lane_c[l][0] <= pre_in[l];
      end
      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
         qea_cordic_cell u_cell (
            .clock(clock), .en(en), .step_idx(TAB_W'(i)),
            .lane_i(lane_c[l][i]), .lane_o(lane_c[l][i+1])
         );
      end
   end

   always_comb begin
      ax = to_angle(lane_c[0][CORDIC_STEPS].acc, lane_c[0][CORDIC_STEPS].zero, LIM_X);
      ay = to_angle(lane_c[1][CORDIC_STEPS].acc, lane_c[1][CORDIC_STEPS].zero, LIM_Y);
      az = to_angle(lane_c[2][CORDIC_STEPS].acc, lane_c[2][CORDIC_STEPS].zero, LIM_X);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= ax[15:0];
         ay_ff <= ay[14:0];
         az_ff <= az[15:0];
      end
   end

   assign rsp_valid       = vld_ff[DEPTH-1];
   assign rsp_angle_x_deg = ax_ff;
   assign rsp_angle_y_deg = ay_ff;
   assign rsp_angle_z_deg = az_ff;

   `QEA_ASSERT_IMPLY(a_stall_back, rsp_valid && rsp_stall, req_stall, "stall not passed back")
   `QEA_ASSERT_IMPLY(a_sqrt_range, vld_ff[FRONT_STAGES+SQ_STEPS-1] && (&cell_ok),
      sq_c[SQ_STEPS].res <= RW'(ONE_Q30), "square root above one")
   `QEA_ASSERT_IMPLY(a_y_range, rsp_valid && (LIM_Y < (AW'(1) <<< 14)),
      ($signed(rsp_angle_y_deg) <= LIM_Y) && ($signed(rsp_angle_y_deg) >= -LIM_Y),
      "y angle out of range")
   `QEA_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_angle_x_deg),
      "stalled item changed")
endmodule
`default_nettype wire
